[sv/ghal_pkg.sv]
// shared types and constants of the generational handle allocator
// no dependencies; imported by the allocator top level
package ghal_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 11;
  localparam int HGEN_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_WITHDRAW = 2'd1,
    REQ_RESOLVE  = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_STALE     = 2'd2
  } status_t;

endpackage

[sv/ghal_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module ghal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ghal_outq.sv]
// two-entry result queue: head register plus skid entry
// no dependencies; data width set by the instantiating module
module ghal_outq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] head_r, head_nxt;
  logic [W-1:0] tail_r, tail_nxt;
  logic         pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
    head_nxt = head_r;
    tail_nxt = tail_r;
    case (cnt_r)
      2'd0: begin
        if (push) head_nxt = push_data;
      end
      2'd1: begin
        if (push && pop) head_nxt = push_data;
        else if (push)   tail_nxt = push_data;
      end
      2'd2: begin
        if (pop) head_nxt = tail_r;
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2 || pop))
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

endmodule

[sv/generational_handle_allocator_core.sv]
// top level of the generational handle allocator (slot map with generations)
// depends on ghal_pkg, ghal_ram and ghal_outq
//
// On the accept edge of a transaction the slot's generation word
// (occupied flag plus generation) and the free stack top are read from their
// rams; in the next cycle the handle check, the stack pop or push and the counter
// update run in one pass, the generation word and stack entry are written back,
// and the result enters a two-entry output queue. The generation ram write back
// must land before the next read, so no new transaction is taken during that
// pass, but one is taken while up to one earlier result waits on out_ready.
// Free stack entries hold the slot and its next generation, so a register never
// needs a second ram read. Neither ram is cleared after reset: the fresh issue
// count marks which slots have ever been written, so the block is ready right
// after reset. population_limit is written on the cfg port, which is always ready.
module generational_handle_allocator_core
  import ghal_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int GEN_BITS = 32,
  localparam int SLOT_W  = $clog2(SLOTS),
  localparam int CNT_W   = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_population_limit,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [SLOT_W-1:0]   in_slot_index,
  input  logic [HGEN_W-1:0]   in_generation,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_issued_slot,
  output logic [HGEN_W-1:0]   out_issued_generation,
  output logic [CNT_W-1:0]    out_live_handles
);

  localparam int GM_W  = GEN_BITS + 1;         // occupied flag above generation
  localparam int FS_W  = SLOT_W + GEN_BITS;    // slot above next generation
  localparam int RES_W = STATUS_W + SLOT_W + HGEN_W + CNT_W;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // request registers (payload, no reset)
  logic [REQ_W-1:0]   req_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [HGEN_W-1:0]  hgen_r;

  // control state
  logic               busy_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   fresh_r, fresh_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]   depth_r, depth_nxt;

  logic in_fire;
  logic q_full;

  // ram ports
  logic [GM_W-1:0]   gm_rdata, gm_wdata;
  logic [SLOT_W-1:0] gm_waddr;
  logic              gm_we;
  logic [FS_W-1:0]   fs_rdata, fs_wdata;
  logic [SLOT_W-1:0] fs_waddr, fs_raddr;
  logic              fs_we;
  logic [CNT_W-1:0]  depth_m1;

  // check / update pass
  logic                stored_occ;
  logic [GEN_BITS-1:0] stored_gen, gen_inc;
  logic [SLOT_W-1:0]   pop_slot;
  logic [GEN_BITS-1:0] pop_gen;
  logic                handle_ok, fresh_ok;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [GEN_BITS-1:0] res_gen;
  logic [RES_W-1:0]    res_data, q_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r && !q_full;
  assign in_fire   = in_valid && in_ready;

  // stack top address is taken while idle, so depth_r is settled
  assign depth_m1 = depth_r - CNT_W'(1);
  assign fs_raddr = depth_m1[SLOT_W-1:0];

  ghal_ram #(.WIDTH(GM_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk   (clk),
    .we    (gm_we),
    .waddr (gm_waddr),
    .wdata (gm_wdata),
    .re    (in_fire),
    .raddr (in_slot_index),
    .rdata (gm_rdata)
  );

  ghal_ram #(.WIDTH(FS_W), .DEPTH(SLOTS)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (in_fire),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  assign stored_occ = gm_rdata[GEN_BITS];
  assign stored_gen = gm_rdata[GEN_BITS-1:0];
  assign gen_inc    = GEN_BITS'(stored_gen + GEN_BITS'(1));
  assign pop_slot   = fs_rdata[FS_W-1:GEN_BITS];
  assign pop_gen    = fs_rdata[GEN_BITS-1:0];

  // a handle resolves only if nonzero, ever issued, occupied and current;
  // handle generation bits above GEN_BITS make the compare fail
  assign handle_ok = (hgen_r != '0)
                  && (CNT_W'(slot_r) < fresh_r)
                  && stored_occ
                  && (HGEN_W'(stored_gen) == hgen_r);

  // fresh issue stops at the limit and at the array size
  assign fresh_ok = (CMP_W'(fresh_r) < CMP_W'(limit_r)) && (fresh_r < SLOTS_CNT);

  always_comb begin
    res_status = ST_STALE;
    res_slot   = '0;
    res_gen    = '0;
    fresh_nxt  = fresh_r;
    live_nxt   = live_r;
    depth_nxt  = depth_r;
    gm_we      = 1'b0;
    gm_waddr   = slot_r;
    gm_wdata   = {1'b0, gen_inc};
    fs_we      = 1'b0;
    fs_waddr   = depth_r[SLOT_W-1:0];
    fs_wdata   = {slot_r, gen_inc};
    if (busy_r) begin
      unique case (req_t'(req_r))
        REQ_REGISTER: begin
          if (depth_r != '0) begin
            // reuse the most recently released slot
            depth_nxt  = depth_m1;
            res_slot   = pop_slot;
            res_gen    = pop_gen;
            res_status = ST_OK;
            live_nxt   = live_r + CNT_W'(1);
            gm_we      = 1'b1;
            gm_waddr   = pop_slot;
            gm_wdata   = {1'b1, pop_gen};
          end else if (fresh_ok) begin
            // fresh slot starts at generation one
            res_slot   = fresh_r[SLOT_W-1:0];
            res_gen    = GEN_BITS'(1);
            res_status = ST_OK;
            fresh_nxt  = fresh_r + CNT_W'(1);
            live_nxt   = live_r + CNT_W'(1);
            gm_we      = 1'b1;
            gm_waddr   = fresh_r[SLOT_W-1:0];
            gm_wdata   = {1'b1, GEN_BITS'(1)};
          end else begin
            res_status = ST_EXHAUSTED;
          end
        end
        REQ_WITHDRAW: begin
          if (handle_ok) begin
            // free the slot, advance its generation, push it
            res_status = ST_OK;
            gm_we      = 1'b1;
            if (depth_r < SLOTS_CNT) begin
              fs_we     = 1'b1;
              depth_nxt = depth_r + CNT_W'(1);
            end
            if (live_r != '0) begin
              live_nxt = live_r - CNT_W'(1);
            end
          end
        end
        REQ_RESOLVE: begin
          res_status = handle_ok ? ST_OK : ST_STALE;
        end
        default: begin
          res_status = ST_STALE;
        end
      endcase
    end
  end

  assign res_data = {res_status, res_slot, HGEN_W'(res_gen), live_nxt};

  ghal_outq #(.W(RES_W)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (busy_r),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_status            = q_data[RES_W-1 -: STATUS_W];
  assign out_issued_slot       = q_data[RES_W-STATUS_W-1 -: SLOT_W];
  assign out_issued_generation = q_data[CNT_W+HGEN_W-1 -: HGEN_W];
  assign out_live_handles      = q_data[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      limit_r <= LIMIT_RESET;
      fresh_r <= '0;
      live_r  <= '0;
      depth_r <= '0;
    end else begin
      busy_r  <= in_fire;
      fresh_r <= fresh_nxt;
      live_r  <= live_nxt;
      depth_r <= depth_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_population_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_req_type;
      slot_r <= in_slot_index;
      hgen_r <= in_generation;
    end
  end

  // ram write back must land before the next transaction reads
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("transaction accepted during write back");

  // every fresh slot is either live or on the free stack
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(depth_r) + (CNT_W+1)'(live_r) == (CNT_W+1)'(fresh_r))
    else $error("live count and free stack depth out of balance");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> ($stable(fresh_r) && $stable(live_r) && $stable(depth_r)))
    else $error("allocator counters changed without a transaction");

endmodule

[test/tb_generational_handle_allocator_core.sv]
// testbench for generational_handle_allocator_core: directed table, then random phases
// depends on ghal_pkg and the allocator top level; keeps its own slot map to predict results
module tb_generational_handle_allocator_core;
  import ghal_pkg::*;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W = 10;
  localparam int CNT_W = 11;
  // undefined request code, not part of req_t
  localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;
  // no transaction on any channel for this long ends the run
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [HGEN_W-1:0]  gen;
    logic [CNT_W-1:0]   live;
  } alloc_result_t;

  localparam alloc_result_t NO_RES = '0;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [REQ_W-1:0]   req;
    logic [SLOT_W-1:0]  slot;
    logic [HGEN_W-1:0]  gen;
    logic [LIMIT_W-1:0] limit;
    bit                 typed;
    alloc_result_t      res;
  } plan_row_t;

  // directed part: typed results only where they follow at a glance
  localparam int PLAN_ROWS = 28;
  plan_row_t plan [PLAN_ROWS] = '{
    // empty map right after reset
    '{ROW_REQ, REQ_RESOLVE, 10'd0, 32'd1, 11'd0, 1'b1, '{ST_STALE, 10'd0, 32'd0, 11'd0}},
    '{ROW_REQ, REQ_WITHDRAW, 10'd1023, 32'hFFFF_FFFF, 11'd0, 1'b1,
      '{ST_STALE, 10'd0, 32'd0, 11'd0}},
    '{ROW_REQ, REQ_UNDEFINED, 10'd1023, 32'd0, 11'd0, 1'b1, '{ST_STALE, 10'd0, 32'd0, 11'd0}},
    // zero limit refuses the very first register
    '{ROW_CFG, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_EXHAUSTED, 10'd0, 32'd0, 11'd0}},
    '{ROW_CFG, REQ_REGISTER, 10'd0, 32'd0, 11'd1, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_OK, 10'd0, 32'd1, 11'd1}},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_EXHAUSTED, 10'd0, 32'd0, 11'd1}},
    '{ROW_REQ, REQ_RESOLVE, 10'd0, 32'd1, 11'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 11'd1}},
    // zero or wrong generation never resolves
    '{ROW_REQ, REQ_RESOLVE, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_STALE, 10'd0, 32'd0, 11'd1}},
    '{ROW_REQ, REQ_RESOLVE, 10'd0, 32'hFFFF_FFFF, 11'd0, 1'b1,
      '{ST_STALE, 10'd0, 32'd0, 11'd1}},
    '{ROW_REQ, REQ_WITHDRAW, 10'd0, 32'd1, 11'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 11'd0}},
    // old handle is stale, double withdraw refused
    '{ROW_REQ, REQ_RESOLVE, 10'd0, 32'd1, 11'd0, 1'b1, '{ST_STALE, 10'd0, 32'd0, 11'd0}},
    '{ROW_REQ, REQ_WITHDRAW, 10'd0, 32'd1, 11'd0, 1'b1, '{ST_STALE, 10'd0, 32'd0, 11'd0}},
    // released slot is reused even with the limit reached
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_OK, 10'd0, 32'd2, 11'd1}},
    // limit above the array
    '{ROW_CFG, REQ_REGISTER, 10'd0, 32'd0, 11'd2047, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_WITHDRAW, 10'd1, 32'd1, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_WITHDRAW, 10'd2, 32'd1, 11'd0, 1'b0, NO_RES},
    // lifo order: slot 2 comes back first
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b0, NO_RES},
    // slot never issued
    '{ROW_REQ, REQ_RESOLVE, 10'd3, 32'd1, 11'd0, 1'b0, NO_RES},
    '{ROW_REQ, REQ_RESOLVE, 10'd1023, 32'hFFFF_FFFF, 11'd0, 1'b1,
      '{ST_STALE, 10'd0, 32'd0, 11'd3}},
    // limit lowered below the issued count
    '{ROW_CFG, REQ_REGISTER, 10'd0, 32'd0, 11'd1, 1'b0, NO_RES},
    '{ROW_REQ, REQ_REGISTER, 10'd0, 32'd0, 11'd0, 1'b1, '{ST_EXHAUSTED, 10'd0, 32'd0, 11'd3}},
    '{ROW_REQ, REQ_WITHDRAW, 10'd2, 32'd2, 11'd0, 1'b0, NO_RES},
    // register ignores the handle fields
    '{ROW_REQ, REQ_REGISTER, 10'd1023, 32'hFFFF_FFFF, 11'd0, 1'b0, NO_RES}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_population_limit;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type;
  logic [SLOT_W-1:0]   in_slot_index;
  logic [HGEN_W-1:0]   in_generation;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_issued_slot;
  logic [HGEN_W-1:0]   out_issued_generation;
  logic [CNT_W-1:0]    out_live_handles;

  // shadow slot map, updated on every accepted request transaction
  bit [HGEN_W-1:0] slot_gen [SLOT_COUNT];
  bit              slot_busy [SLOT_COUNT];
  bit [SLOT_W-1:0] free_slots [SLOT_COUNT];
  int unsigned     free_count = 0;
  int unsigned     fresh_count = 0;
  int unsigned     live_count = 0;
  int unsigned     pop_limit = LIMIT_RESET;

  alloc_result_t owed_replies [$];
  alloc_result_t oldest_reply;

  int  requests_sent = 0;
  int  replies_seen = 0;
  int  mismatches = 0;
  int  refusals = 0;
  int  peak_live = 0;
  int  quiet_cycles = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 10;
  bit  quiet_tail = 1'b0;
  bit  hold_done = 1'b0;

  generational_handle_allocator_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_population_limit  (cfg_population_limit),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_slot_index         (in_slot_index),
    .in_generation         (in_generation),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_issued_slot       (out_issued_slot),
    .out_issued_generation (out_issued_generation),
    .out_live_handles      (out_live_handles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a handle is good only if nonzero, issued, occupied and of the current generation
  function automatic bit handle_resolves(logic [SLOT_W-1:0] s, logic [HGEN_W-1:0] g);
    return g != '0 && s < fresh_count && slot_busy[s] && slot_gen[s] == g;
  endfunction

  // advance the shadow map by one request and return its result
  function automatic alloc_result_t apply_handle_request(logic [REQ_W-1:0] req,
                                                         logic [SLOT_W-1:0] s,
                                                         logic [HGEN_W-1:0] g);
    alloc_result_t r;
    bit got;
    bit [SLOT_W-1:0] pick;
    r = NO_RES;
    r.status = ST_STALE;
    got = 1'b0;
    pick = '0;
    case (req)
      REQ_REGISTER: begin
        // lifo reuse first, then a fresh slot while both the limit and the array allow
        if (free_count > 0) begin
          free_count--;
          pick = free_slots[free_count];
          got = 1'b1;
        end else if (fresh_count < pop_limit && fresh_count < SLOT_COUNT) begin
          pick = SLOT_W'(fresh_count);
          slot_gen[pick] = 1;
          fresh_count++;
          got = 1'b1;
        end
        if (got) begin
          slot_busy[pick] = 1'b1;
          live_count++;
          r.status = ST_OK;
          r.slot = pick;
          r.gen = slot_gen[pick];
        end else begin
          r.status = ST_EXHAUSTED;
          refusals++;
        end
      end
      REQ_WITHDRAW: begin
        if (handle_resolves(s, g)) begin
          slot_busy[s] = 1'b0;
          slot_gen[s] = slot_gen[s] + 1;
          if (free_count < SLOT_COUNT) begin
            free_slots[free_count] = s;
            free_count++;
          end
          if (live_count > 0)
            live_count--;
          r.status = ST_OK;
        end
      end
      REQ_RESOLVE: begin
        if (handle_resolves(s, g))
          r.status = ST_OK;
      end
      default: ;
    endcase
    r.live = CNT_W'(live_count);
    if (live_count > peak_live)
      peak_live = live_count;
    return r;
  endfunction

  // one request transaction: optional idle burst, then hold valid until accepted
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] s,
                              input logic [HGEN_W-1:0] g, input bit typed,
                              input alloc_result_t typed_res);
    int gap;
    alloc_result_t predicted;
    if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = req;
    in_slot_index = s;
    in_generation = g;
    do @(posedge clk); while (!in_ready);
    predicted = apply_handle_request(req, s, g);
    // typed rows check the table value, the shadow map still advances
    owed_replies.insert(owed_replies.size(), typed ? typed_res : predicted);
    requests_sent++;
  endtask

  // drop valid and let every owed result come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // limit writes only with the block idle
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_population_limit = v;
    do @(posedge clk); while (!cfg_ready);
    pop_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly live handles, else stale flavors: old or current generation of a freed
  // slot, zero generation, never-issued slot, or fully random
  task automatic pick_handle(output logic [SLOT_W-1:0] s, output logic [HGEN_W-1:0] g);
    int start;
    int unsigned idx;
    s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    g = $urandom();
    if (fresh_count == 0)
      return;
    start = $urandom_range(0, fresh_count - 1);
    s = SLOT_W'(start);
    if ($urandom_range(0, 99) < 70 && live_count > 0) begin
      for (int i = 0; i < fresh_count; i++) begin
        idx = (start + i) % fresh_count;
        if (slot_busy[idx]) begin
          s = SLOT_W'(idx);
          break;
        end
      end
      g = slot_gen[s];
    end else begin
      case ($urandom_range(0, 4))
        0: s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        1: g = slot_gen[s] - 1;
        2: g = '0;
        3: g = slot_gen[s];
        default: begin
          if (fresh_count < SLOT_COUNT)
            s = SLOT_W'($urandom_range(fresh_count, SLOT_COUNT - 1));
          g = $urandom_range(1, 3);
        end
      endcase
    end
  endtask

  // weighted mix; a few percent undefined requests, the rest resolves
  task automatic random_request(input int reg_pct, input int wd_pct);
    int roll;
    logic [SLOT_W-1:0] s;
    logic [HGEN_W-1:0] g;
    roll = $urandom_range(0, 99);
    pick_handle(s, g);
    if (roll < reg_pct)
      send_request(REQ_REGISTER, s, g, 1'b0, NO_RES);
    else if (roll < reg_pct + wd_pct)
      send_request(REQ_WITHDRAW, s, g, 1'b0, NO_RES);
    else if (roll < reg_pct + wd_pct + 4)
      send_request(REQ_UNDEFINED, s, g, 1'b0, NO_RES);
    else
      send_request(REQ_RESOLVE, s, g, 1'b0, NO_RES);
  endtask

  task automatic run_phase(input int n, input int reg_pct, input int wd_pct,
                           input int idle_pct);
    tx_idle_pct = idle_pct;
    repeat (n) random_request(reg_pct, wd_pct);
  endtask

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (owed_replies.size() == 0) begin
        $error("result with none owed: status %0d live_handles %0d", out_status,
               out_live_handles);
        mismatches++;
      end else begin
        oldest_reply = owed_replies.pop_front();
        if (out_status !== oldest_reply.status) begin
          $error("status: expected %0d, actual %0d", oldest_reply.status, out_status);
          mismatches++;
        end
        if (out_issued_slot !== oldest_reply.slot) begin
          $error("issued_slot: expected %0d, actual %0d", oldest_reply.slot,
                 out_issued_slot);
          mismatches++;
        end
        if (out_issued_generation !== oldest_reply.gen) begin
          $error("issued_generation: expected %0h, actual %0h", oldest_reply.gen,
                 out_issued_generation);
          mismatches++;
        end
        if (out_live_handles !== oldest_reply.live) begin
          $error("live_handles: expected %0d, actual %0d", oldest_reply.live,
                 out_live_handles);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results owed", quiet_cycles,
               owed_replies.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off to back the block up,
  // stall rate reshuffled every 200 passes of its loop, none in the tail
  initial begin : result_sink
    int burst;
    int sink_cycles;
    sink_cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      sink_cycles++;
      if (sink_cycles % 200 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 8;
          default: rx_idle_pct = 30;
        endcase
      end
      if (!hold_done && replies_seen >= 60) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready = 1'b0;
        burst = $urandom_range(1, 17);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int refused_mark;
    int guard;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_population_limit = LIMIT_RESET;
    in_valid = 1'b0;
    in_req_type = REQ_REGISTER;
    in_slot_index = '0;
    in_generation = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG)
        write_limit(plan[i].limit);
      else
        send_request(plan[i].req, plan[i].slot, plan[i].gen, plan[i].typed, plan[i].res);
    end

    // small limit, the long receiver hold-off lands here
    write_limit(11'd12);
    run_phase(120, 40, 30, 20);
    // only reuse possible, sender never idles
    write_limit(11'd0);
    run_phase(80, 45, 35, 0);
    write_limit(LIMIT_W'($urandom_range(30, 90)));
    run_phase(120, 50, 25, 35);

    // fill the whole array until a register is refused at the array size
    write_limit(11'd2047);
    tx_idle_pct = 10;
    refused_mark = refusals;
    guard = 0;
    while (refusals == refused_mark && guard < 1400) begin
      random_request(92, 4);
      guard++;
    end
    run_phase(40, 40, 35, 10);

    // back to the reset limit, no idling on either side
    write_limit(LIMIT_RESET);
    quiet_tail = 1'b1;
    run_phase(100, 40, 30, 0);

    settle();
    repeat (8) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d registers refused", requests_sent,
             replies_seen, refusals);
    $display("peak of %0d live handles over %0d fresh slots, limits from 0 to 2047",
             peak_live, fresh_count);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[generational_handle_allocator_core.f]
sv/ghal_pkg.sv
sv/ghal_ram.sv
sv/ghal_outq.sv
sv/generational_handle_allocator_core.sv
test/tb_generational_handle_allocator_core.sv
